// ----- rtl/assert_macros.svh -----
// Assertion shorthands shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define FTL_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("forwarding table assertion failed");

// Check that a condition implies another one in the next cycle.
`define FTL_ASSERT_NEXT(name, clk, rst_n, cond, res) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("forwarding table assertion failed");

`endif

// ----- rtl/ftl_pkg.sv -----
package ftl_pkg;

    // Table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES + 1);
    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths
    localparam int ADDR_W   = 16;
    localparam int HOP_W    = 8;
    localparam int DELAY_W  = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int REG_W    = 2;
    localparam int DATA_W   = 16;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_MATCHED   = 3'd3,
        ST_DEFAULT   = 3'd4
    } status_t;

    typedef enum logic [REG_W-1:0] {
        REG_DEFAULT_HOP     = 2'd0,
        REG_DEFAULT_DELAY   = 2'd1,
        REG_DEFAULT_PRESENT = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ftl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic at_end;
        logic hit;
    } ftl_sts_t;

endpackage

// ----- rtl/ftl_item_if.sv -----
interface ftl_item_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [ftl_pkg::ADDR_W-1:0]     dest_address;
    logic [ftl_pkg::HOP_W-1:0]      hop_id;
    logic [ftl_pkg::DELAY_W-1:0]    link_delay;

    modport source (
        output valid, command, dest_address, hop_id, link_delay,
        input  ready
    );
    modport sink (
        input  valid, command, dest_address, hop_id, link_delay,
        output ready
    );
endinterface

// ----- rtl/ftl_result_if.sv -----
interface ftl_result_if;
    logic                           valid;
    logic                           ready;
    logic [ftl_pkg::STATUS_W-1:0]   status;
    logic                           route_valid;
    logic [ftl_pkg::HOP_W-1:0]      result_hop;
    logic [ftl_pkg::DELAY_W-1:0]    result_delay;
    logic [ftl_pkg::COUNT_W-1:0]    entry_count;

    modport source (
        output valid, status, route_valid, result_hop, result_delay, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, route_valid, result_hop, result_delay, entry_count,
        output ready
    );
endinterface

// ----- rtl/ftl_cfg_if.sv -----
interface ftl_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ftl_pkg::REG_W-1:0]      index;
    logic [ftl_pkg::DATA_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- rtl/forwarding_table_lookup.sv -----
// Exact-match forwarding table with a default route.
// item_in carries one command per item: insert an address with a hop id and
// link delay, or look up an address. result_out returns exactly one item per
// command with status, route_valid, result_hop, result_delay and entry_count.
// cfg writes the default route: index 0 hop, 1 delay, 2 present bit; it is
// always ready and takes effect on the next cycle.
// An item walks the stored entries one per cycle in insertion order and stops
// at the first match or at the fill count. The item is taken in the idle
// state, the walk runs in the search state, and the finish state loads the
// result register and goes back to idle; only then is the next item taken, so
// a new item never starts before the last one is through. Each walk step reads
// the table through its single read port.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following result is held in its final
// step and the block takes no new item until the register frees.
// Reset empties the table and clears the default route; no clearing pass is
// needed, since entries at or above the fill count are never used.
module forwarding_table_lookup (
    input  logic         clk,
    input  logic         rst_n,
    ftl_item_if.sink     item_in,
    ftl_result_if.source result_out,
    ftl_cfg_if.sink      cfg
);

    ftl_pkg::ftl_cmd_t cmd;
    ftl_pkg::ftl_sts_t sts;

    ftl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .result_out (result_out),
        .sts        (sts),
        .cmd        (cmd)
    );

    ftl_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .result_out (result_out),
        .cfg        (cfg),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

// ----- rtl/ftl_dp.sv -----
`include "assert_macros.svh"

module ftl_dp (
    input  logic              clk,
    input  logic              rst_n,
    ftl_item_if.sink          item_in,
    ftl_result_if.source      result_out,
    ftl_cfg_if.sink           cfg,
    input  ftl_pkg::ftl_cmd_t cmd,
    output ftl_pkg::ftl_sts_t sts
);

    // Held item
    ftl_pkg::command_t               command_reg;
    logic [ftl_pkg::ADDR_W-1:0]      address_reg;
    logic [ftl_pkg::HOP_W-1:0]       hop_reg;
    logic [ftl_pkg::DELAY_W-1:0]     delay_reg;

    // Table storage and walk state
    logic [ftl_pkg::ADDR_W-1:0]      address_store [ftl_pkg::ENTRIES];
    logic [ftl_pkg::HOP_W-1:0]       hop_store     [ftl_pkg::ENTRIES];
    logic [ftl_pkg::DELAY_W-1:0]     delay_store   [ftl_pkg::ENTRIES];
    logic [ftl_pkg::ADDR_W-1:0]      address_rd_reg;
    logic [ftl_pkg::HOP_W-1:0]       hop_rd_reg;
    logic [ftl_pkg::DELAY_W-1:0]     delay_rd_reg;
    logic [ftl_pkg::IDX_W-1:0]       index_reg;
    logic [ftl_pkg::IDX_W-1:0]       index_next;
    logic [ftl_pkg::IDX_W-1:0]       fill_count_reg;
    logic [ftl_pkg::IDX_W-1:0]       fill_count_next;
    logic [ftl_pkg::SLOT_W-1:0]      read_slot;
    logic [ftl_pkg::SLOT_W-1:0]      write_slot;

    // Default route registers
    logic [ftl_pkg::HOP_W-1:0]       default_hop_reg;
    logic [ftl_pkg::DELAY_W-1:0]     default_delay_reg;
    logic                            default_present_reg;

    // Result register
    ftl_pkg::status_t                status_reg;
    ftl_pkg::status_t                status_next;
    logic                            route_valid_reg;
    logic                            route_valid_next;
    logic [ftl_pkg::HOP_W-1:0]       result_hop_reg;
    logic [ftl_pkg::HOP_W-1:0]       result_hop_next;
    logic [ftl_pkg::DELAY_W-1:0]     result_delay_reg;
    logic [ftl_pkg::DELAY_W-1:0]     result_delay_next;
    logic [ftl_pkg::COUNT_W-1:0]     entry_count_reg;

    logic                            found;
    logic                            table_full;
    logic                            write_en;

    // Read ahead at the next walk position so the read register tracks index_reg
    assign read_slot  = index_next[ftl_pkg::SLOT_W-1:0];
    assign write_slot = fill_count_reg[ftl_pkg::SLOT_W-1:0];

    // Compare the walked entry against the held address
    assign sts.at_end = (index_reg == fill_count_reg);
    assign sts.hit    = !sts.at_end && (address_rd_reg == address_reg);

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= ftl_pkg::command_t'(item_in.command);
            address_reg <= item_in.dest_address;
            hop_reg     <= item_in.hop_id;
            delay_reg   <= item_in.link_delay;
        end
    end

    // Walk index
    always_comb
    begin
        index_next = index_reg;
        if (cmd.load)
        begin
            index_next = '0;
        end
        else if (cmd.step)
        begin
            index_next = index_reg + ftl_pkg::IDX_W'(1);
        end
    end

    // Decide the outcome once the walk has stopped
    always_comb
    begin
        found             = !sts.at_end;
        table_full        = (fill_count_reg == ftl_pkg::IDX_W'(ftl_pkg::ENTRIES));
        write_en          = 1'b0;
        status_next       = ftl_pkg::ST_DEFAULT;
        route_valid_next  = 1'b0;
        result_hop_next   = '0;
        result_delay_next = '0;
        if (command_reg == ftl_pkg::CMD_INSERT)
        begin
            if (table_full)
            begin
                status_next = ftl_pkg::ST_FULL;
            end
            else if (found)
            begin
                status_next = ftl_pkg::ST_DUPLICATE;
            end
            else
            begin
                status_next = ftl_pkg::ST_INSERTED;
                write_en    = cmd.finish;
            end
        end
        else if (found)
        begin
            status_next       = ftl_pkg::ST_MATCHED;
            route_valid_next  = 1'b1;
            result_hop_next   = hop_rd_reg;
            result_delay_next = delay_rd_reg;
        end
        else if (default_present_reg)
        begin
            route_valid_next  = 1'b1;
            result_hop_next   = default_hop_reg;
            result_delay_next = default_delay_reg;
        end
        fill_count_next = write_en ? fill_count_reg + ftl_pkg::IDX_W'(1) : fill_count_reg;
    end

    // Walk and fill counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg      <= '0;
            fill_count_reg <= '0;
        end
        else
        begin
            index_reg      <= index_next;
            fill_count_reg <= fill_count_next;
        end
    end

    // Append a new entry at the fill position and read the next walk slot
    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            address_store[write_slot] <= address_reg;
            hop_store[write_slot]     <= hop_reg;
            delay_store[write_slot]   <= delay_reg;
        end
        address_rd_reg <= address_store[read_slot];
        hop_rd_reg     <= hop_store[read_slot];
        delay_rd_reg   <= delay_store[read_slot];
    end

    // Default route registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_hop_reg     <= '0;
            default_delay_reg   <= '0;
            default_present_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ftl_pkg::REG_DEFAULT_HOP:
                begin
                    default_hop_reg <= cfg.data[ftl_pkg::HOP_W-1:0];
                end
                ftl_pkg::REG_DEFAULT_DELAY:
                begin
                    default_delay_reg <= cfg.data[ftl_pkg::DELAY_W-1:0];
                end
                ftl_pkg::REG_DEFAULT_PRESENT:
                begin
                    default_present_reg <= cfg.data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg       <= status_next;
            route_valid_reg  <= route_valid_next;
            result_hop_reg   <= result_hop_next;
            result_delay_reg <= result_delay_next;
            entry_count_reg  <= ftl_pkg::COUNT_W'(fill_count_next);
        end
    end

    assign result_out.status       = status_reg;
    assign result_out.route_valid  = route_valid_reg;
    assign result_out.result_hop   = result_hop_reg;
    assign result_out.result_delay = result_delay_reg;
    assign result_out.entry_count  = entry_count_reg;

    `FTL_ASSERT(a_fill_bound, clk, rst_n, fill_count_reg <= ftl_pkg::IDX_W'(ftl_pkg::ENTRIES))
    `FTL_ASSERT_NEXT(a_fill_hold, clk, rst_n, !cmd.finish, $stable(fill_count_reg))
    `FTL_ASSERT(a_step_in_range, clk, rst_n, cmd.step |-> (!sts.at_end && !sts.hit))

endmodule

// ----- rtl/ftl_ctrl.sv -----
`include "assert_macros.svh"

module ftl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    ftl_item_if.sink          item_in,
    ftl_result_if.source      result_out,
    input  ftl_pkg::ftl_sts_t sts,
    output ftl_pkg::ftl_cmd_t cmd
);

    ftl_pkg::ctrl_state_t state_reg;
    ftl_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 slot_free;
    logic                 item_accept;

    assign slot_free   = !out_valid_reg || result_out.ready;
    assign item_accept = item_in.valid && item_in.ready;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        item_in.ready = 1'b0;
        cmd           = '0;
        case (state_reg)
            ftl_pkg::S_IDLE:
            begin
                item_in.ready = 1'b1;
                if (item_in.valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ftl_pkg::S_SEARCH;
                end
            end
            ftl_pkg::S_SEARCH:
            begin
                if (sts.at_end || sts.hit)
                begin
                    state_next = ftl_pkg::S_FINISH;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ftl_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ftl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ftl_pkg::S_IDLE;
            end
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ftl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_out.valid = out_valid_reg;

    `FTL_ASSERT_NEXT(a_accept_search, clk, rst_n, item_accept, state_reg == ftl_pkg::S_SEARCH)
    `FTL_ASSERT_NEXT(a_finish_shows, clk, rst_n, cmd.finish, out_valid_reg)
    `FTL_ASSERT(a_no_overwrite, clk, rst_n, (out_valid_reg && !result_out.ready) |-> !cmd.finish)

endmodule

// ----- sim/route_check_pkg.sv -----
package route_check_pkg;

    import ftl_pkg::*;

    // One result item as the table should return it
    typedef struct {
        status_t                status;
        logic                   route_valid;
        logic [HOP_W-1:0]       hop;
        logic [DELAY_W-1:0]     delay;
        logic [COUNT_W-1:0]     count;
    } route_result_t;

    class route_checker;

        // Shadow copy of the forwarding table and the default route
        logic [ADDR_W-1:0]      addr_tab[ENTRIES];
        logic [HOP_W-1:0]       hop_tab[ENTRIES];
        logic [DELAY_W-1:0]     delay_tab[ENTRIES];
        int unsigned            fill;
        logic [HOP_W-1:0]       dflt_hop;
        logic [DELAY_W-1:0]     dflt_delay;
        logic                   dflt_on;

        route_result_t          expected_routes[$];
        int unsigned            failures;

        function new();
            fill       = 0;
            dflt_hop   = '0;
            dflt_delay = '0;
            dflt_on    = 1'b0;
            failures   = 0;
        endfunction

        // Track a register write; unknown indexes are dropped
        function void write_register(logic [REG_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_DEFAULT_HOP:     dflt_hop   = data[HOP_W-1:0];
                REG_DEFAULT_DELAY:   dflt_delay = data[DELAY_W-1:0];
                REG_DEFAULT_PRESENT: dflt_on    = data[0];
                default:             ;
            endcase
        endfunction

        function bit stores(logic [ADDR_W-1:0] addr);
            for (int i = 0; i < fill; i++)
                if (addr_tab[i] == addr)
                    return 1'b1;
            return 1'b0;
        endfunction

        function int unsigned outstanding();
            return expected_routes.size();
        endfunction

        // Apply one accepted command to the shadow table and queue its result
        function void note_command(command_t cmd, logic [ADDR_W-1:0] addr,
                                   logic [HOP_W-1:0] hop, logic [DELAY_W-1:0] dly);
            route_result_t r;
            bit            hit;
            int unsigned   slot;
            r.status      = ST_DEFAULT;
            r.route_valid = 1'b0;
            r.hop         = '0;
            r.delay       = '0;
            hit           = 1'b0;
            slot          = 0;
            // first match in insertion order
            for (int i = 0; i < fill; i++)
            begin
                if (!hit && addr_tab[i] == addr)
                begin
                    hit  = 1'b1;
                    slot = i;
                end
            end
            if (cmd == CMD_INSERT)
            begin
                // a full table refuses before any duplicate check
                if (fill >= ENTRIES)
                    r.status = ST_FULL;
                else if (hit)
                    r.status = ST_DUPLICATE;
                else
                begin
                    addr_tab[fill]  = addr;
                    hop_tab[fill]   = hop;
                    delay_tab[fill] = dly;
                    fill++;
                    r.status = ST_INSERTED;
                end
            end
            else if (hit)
            begin
                r.status      = ST_MATCHED;
                r.route_valid = 1'b1;
                r.hop         = hop_tab[slot];
                r.delay       = delay_tab[slot];
            end
            else if (dflt_on)
            begin
                r.route_valid = 1'b1;
                r.hop         = dflt_hop;
                r.delay       = dflt_delay;
            end
            r.count = COUNT_W'(fill);
            expected_routes.push_back(r);
        endfunction

        // Compare one accepted result item with the oldest expectation
        function void check_route(logic [STATUS_W-1:0] st, logic rv, logic [HOP_W-1:0] hop,
                                  logic [DELAY_W-1:0] dly, logic [COUNT_W-1:0] cnt);
            route_result_t e;
            if (expected_routes.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d valid=%0d hop=%h delay=%h count=%0d",
                         $time, st, rv, hop, dly, cnt);
                failures++;
                return;
            end
            e = expected_routes.pop_front();
            if (st !== e.status || rv !== e.route_valid || hop !== e.hop
                || dly !== e.delay || cnt !== e.count)
            begin
                $display("%0t: mismatch expected status=%0d valid=%0d hop=%h delay=%h count=%0d",
                         $time, e.status, e.route_valid, e.hop, e.delay, e.count);
                $display("%0t:          actual   status=%0d valid=%0d hop=%h delay=%h count=%0d",
                         $time, st, rv, hop, dly, cnt);
                failures++;
            end
        endfunction

    endclass

endpackage

// ----- sim/tb_top.sv -----
module tb_top;

    import ftl_pkg::*;
    import route_check_pkg::*;

    localparam int              CYCLE_LIMIT   = 400000;
    localparam int              PHASE_ITEMS   = 225;
    localparam int              HOLD_CYCLES   = 400;
    localparam logic [REG_W-1:0] REG_SPARE    = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ftl_item_if   item_bus();
    ftl_result_if result_bus();
    ftl_cfg_if    cfg_bus();

    forwarding_table_lookup dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_bus),
        .result_out (result_bus),
        .cfg        (cfg_bus)
    );

    route_checker routes = new();

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_request  = 0;
    int          hold_left     = 0;
    int unsigned cycle_count   = 0;

    always #5 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Check accepted results, then stall or hold off the result channel
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            routes.check_route(result_bus.status, result_bus.route_valid,
                               result_bus.result_hop, result_bus.result_delay,
                               result_bus.entry_count);
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            result_bus.ready <= 1'b0;
            hold_left--;
        end
        else
            result_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Offer one item after a random gap and wait until it is taken
    task automatic send_item(command_t cmd, logic [ADDR_W-1:0] addr,
                             logic [HOP_W-1:0] hop, logic [DELAY_W-1:0] dly);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid        <= 1'b1;
        item_bus.command      <= cmd;
        item_bus.dest_address <= addr;
        item_bus.hop_id       <= hop;
        item_bus.link_delay   <= dly;
        @(posedge clk);
        while (item_bus.ready !== 1'b1)
            @(posedge clk);
        routes.note_command(cmd, addr, hop, dly);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_for_results();
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (routes.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (cfg_bus.ready !== 1'b1)
            @(posedge clk);
        routes.write_register(idx, data);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly stored addresses, some extremes, the rest random
    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 && routes.fill > 0)
            return routes.addr_tab[$urandom_range(0, routes.fill - 1)];
        else if (r < 62)
            return '0;
        else if (r < 69)
            return '1;
        return ADDR_W'($urandom);
    endfunction

    task automatic run_phase(int send_pct, int stall, int hold_at, int pause_at);
        command_t cmd;
        send_idle_pct = send_pct;
        stall_pct     = stall;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i == hold_at)
                hold_request = HOLD_CYCLES;
            if (i == pause_at)
                wait_for_results();
            cmd = ($urandom_range(0, 99) < 25) ? CMD_INSERT : CMD_LOOKUP;
            send_item(cmd, pick_address(), HOP_W'($urandom), DELAY_W'($urandom));
        end
        wait_for_results();
    endtask

    initial
    begin
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] last_addr;

        item_bus.valid        = 1'b0;
        item_bus.command      = CMD_INSERT;
        item_bus.dest_address = '0;
        item_bus.hop_id       = '0;
        item_bus.link_delay   = '0;
        result_bus.ready      = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = REG_DEFAULT_HOP;
        cfg_bus.data          = '0;
        last_addr             = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, no default: no route
        send_item(CMD_LOOKUP, 16'h1234, 8'h5A, 16'hA5A5);
        // Extreme addresses and payloads, then a duplicate
        send_item(CMD_INSERT, 16'h0000, 8'h00, 16'h0000);
        send_item(CMD_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_item(CMD_INSERT, 16'h0000, 8'hFF, 16'hFFFF);
        send_item(CMD_LOOKUP, 16'h0000, 8'hFF, 16'hFFFF);
        send_item(CMD_LOOKUP, 16'hFFFF, 8'h00, 16'h0000);
        send_item(CMD_LOOKUP, 16'h8000, 8'h00, 16'h0000);

        // Set a default route, then miss
        wait_for_results();
        write_reg(REG_DEFAULT_HOP, 16'h00AB);
        write_reg(REG_DEFAULT_DELAY, 16'h5A5A);
        write_reg(REG_DEFAULT_PRESENT, 16'h0001);
        send_item(CMD_LOOKUP, 16'h7FFF, 8'h00, 16'h0000);

        // Fill the table with distinct random entries
        while (routes.fill < ENTRIES)
        begin
            do
                addr = ADDR_W'($urandom);
            while (routes.stores(addr));
            last_addr = addr;
            send_item(CMD_INSERT, addr, HOP_W'($urandom), DELAY_W'($urandom));
        end

        // Full table: full wins over duplicate; deepest match
        send_item(CMD_INSERT, 16'hFFFF, 8'h11, 16'h2222);
        send_item(CMD_INSERT, last_addr ^ 16'h8000, 8'h33, 16'h4444);
        send_item(CMD_LOOKUP, last_addr, 8'h00, 16'h0000);
        wait_for_results();

        // Random phases, default route changed between them
        write_reg(REG_DEFAULT_HOP, 16'h00FF);
        write_reg(REG_DEFAULT_DELAY, 16'hFFFF);
        run_phase(0, 0, 40, -1);

        write_reg(REG_DEFAULT_HOP, 16'h0000);
        write_reg(REG_DEFAULT_DELAY, 16'h0000);
        run_phase(52, 0, -1, 100);

        write_reg(REG_DEFAULT_HOP, 16'hFF37);
        write_reg(REG_DEFAULT_PRESENT, 16'hFFFE);
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_DEFAULT_DELAY, DATA_W'($urandom));
        run_phase(0, 52, -1, -1);

        write_reg(REG_DEFAULT_PRESENT, 16'hFFFF);
        write_reg(REG_DEFAULT_HOP, DATA_W'($urandom));
        write_reg(REG_DEFAULT_DELAY, DATA_W'($urandom));
        run_phase(11, 11, -1, -1);

        // Let any stray result show up
        repeat (ENTRIES + 8) @(posedge clk);
        if (routes.failures == 0 && routes.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ftl_pkg.sv
rtl/ftl_item_if.sv
rtl/ftl_result_if.sv
rtl/ftl_cfg_if.sv
rtl/ftl_dp.sv
rtl/ftl_ctrl.sv
rtl/forwarding_table_lookup.sv
sim/route_check_pkg.sv
sim/tb_top.sv
